// File: src/qjtg_pkg.sv
// Shared types and constants of the quintic joint trajectory generator.
// Used by the top level; depends on nothing.
package qjtg_pkg;

  localparam int JOINTS     = 3;
  localparam int ANGLE_BITS = 16;
  localparam int DELTA_BITS = ANGLE_BITS + 1;
  localparam int STEP_BITS  = ANGLE_BITS + 1;
  localparam int JIDX_BITS  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int SPEED_BITS = 12;
  localparam int NUM_BITS   = 21;
  localparam int DIV_BITS   = 32;
  localparam int DCNT_BITS  = $clog2(DIV_BITS);
  localparam int MUL_BITS   = 18;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int BLEND_BITS = 23;

  localparam int ADDR_BITS  = 3;
  localparam int REG_SPEED  = 0;
  localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(64);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DIV_N,
    ST_CHECK,
    ST_DIV_INC,
    ST_TAU,
    ST_POW2,
    ST_POW3,
    ST_POW4,
    ST_POW5,
    ST_BLEND,
    ST_JMUL,
    ST_JSUM,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

// File: src/quintic_joint_trajectory_generator.sv
// Top level of the quintic joint trajectory generator: sequencer, shared
// restoring divider, shared 18x18 multiplier and the APB register.
// Depends on qjtg_pkg.
//
// A request with func = start plans a synchronized move of three joints from
// the current angles to the targets. It runs two divisions on the shared divider
// and gives no result, unless the move has zero steps, in which case one result
// holding the targets with last set follows.
// A request with func = tick while a move is running gives one sample of the
// three joints; five products for tau and its powers and one product per
// joint go through the single shared multiplier. Ticks while idle and starts
// during a move are taken and give nothing. in_stall is high while an item
// is being worked on.
// The result waits in an output register; a new request is taken while it
// waits, and a following result is held back until out_stall lets the
// previous one go. Payload never changes while out_valid is high and stalled.
// speed_per_tick is written through the APB port at byte address 0, by the user
// only while idle; the block does not enforce it. Reset clears the angles, ends
// any move and empties the output register; speed_per_tick returns to 64.
module quintic_joint_trajectory_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic signed [15:0] in_target_a,
  input  logic signed [15:0] in_target_b,
  input  logic signed [15:0] in_target_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_angle_a,
  output logic signed [15:0] out_angle_b,
  output logic signed [15:0] out_angle_c,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AB = qjtg_pkg::ANGLE_BITS;
  localparam int DB = qjtg_pkg::DELTA_BITS;
  localparam int SB = qjtg_pkg::STEP_BITS;
  localparam int JB = qjtg_pkg::JIDX_BITS;
  localparam int NB = qjtg_pkg::NUM_BITS;
  localparam int VB = qjtg_pkg::DIV_BITS;
  localparam int MB = qjtg_pkg::MUL_BITS;
  localparam int PB = qjtg_pkg::PROD_BITS;
  localparam int BB = qjtg_pkg::BLEND_BITS;
  localparam int WB = qjtg_pkg::SPEED_BITS;
  localparam int NJ = qjtg_pkg::JOINTS;

  qjtg_pkg::state_t state_r, state_nxt;

  logic [WB-1:0]        speed_r;
  logic signed [AB-1:0] cur_r   [NJ];
  logic signed [AB-1:0] start_r [NJ];
  logic signed [DB-1:0] delta_r [NJ];
  logic signed [AB-1:0] tgt_r   [NJ];
  logic signed [AB-1:0] res_r   [NJ];
  logic                 res_last_r;
  logic [15:0]          inc_r;
  logic [SB-1:0]        idx_r;
  logic [SB-1:0]        total_r;
  logic                 moving_r;
  logic [NB-1:0]        num_r;
  logic [15:0]          den_r;
  logic [NB:0]          rem_r;
  logic [VB-1:0]        quo_r;
  logic [NB-1:0]        divisor_r;
  logic [qjtg_pkg::DCNT_BITS-1:0] dcnt_r;
  logic [JB-1:0]        jidx_r;
  logic [15:0]          tau_r, t3_r, t4_r;
  logic [16:0]          s_r;
  logic signed [PB-1:0] prod_r;
  logic signed [AB-1:0] oa_r [NJ];
  logic                 olast_r;
  logic                 ovalid_r;
  logic                 ovalid_nxt;

  logic                 in_acc, out_acc, out_free, cfg_wr;
  logic signed [MB-1:0] mul_a, mul_b;
  logic [15:0]          tau_cap, pw_hi;
  logic signed [DB-1:0] dnew [NJ];
  logic [AB-1:0]        dabs [NJ];
  logic [AB-1:0]        maxabs;
  logic [NB-1:0]        num_new;
  logic [WB-1:0]        speed_eff;
  logic [NB:0]          trial;
  logic signed [BB-1:0] blend;
  logic signed [AB+4:0] jsum;
  logic signed [AB-1:0] jsat;
  logic                 is_last;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite &&
                    (paddr[2] == 1'(qjtg_pkg::REG_SPEED));
  assign prdata   = (paddr[2] == 1'(qjtg_pkg::REG_SPEED)) ? 32'(speed_r) : 32'd0;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ovalid_r && !out_stall;
  assign out_free = !ovalid_r || !out_stall;
  assign ovalid_nxt = (state_r == qjtg_pkg::ST_DONE && out_free) ? 1'b1 :
                      (out_acc ? 1'b0 : ovalid_r);

  assign out_valid   = ovalid_r;
  assign out_angle_a = oa_r[0];
  assign out_angle_b = oa_r[1];
  assign out_angle_c = oa_r[2];
  assign out_last    = olast_r;

  assign tau_cap   = (prod_r[PB-1:16] != '0) ? 16'hFFFF : prod_r[15:0];
  assign pw_hi     = prod_r[31:16];
  assign speed_eff = (speed_r == '0) ? WB'(1) : speed_r;
  assign trial     = {rem_r[NB-1:0], quo_r[VB-1]};
  assign is_last   = (SB'(idx_r + SB'(1)) >= total_r) || (idx_r == '1);

  always_comb begin
    maxabs = '0;
    for (int j = 0; j < NJ; j++) begin
      dnew[j] = DB'(tgt_r[j]) - DB'(cur_r[j]);
      dabs[j] = dnew[j][DB-1] ? AB'(-dnew[j]) : AB'(dnew[j]);
      if (dabs[j] > maxabs) maxabs = dabs[j];
    end
    num_new = (NB'(maxabs) << 5) - (NB'(maxabs) << 1);
  end

  always_comb begin
    blend = BB'(t3_r) * BB'(10) - BB'(t4_r) * BB'(15) + BB'(pw_hi) * BB'(6);
    jsum  = (AB+5)'(start_r[jidx_r]) + (AB+5)'($signed(prod_r[PB-1:16]));
    if (jsum > (AB+5)'(2 ** (AB - 1) - 1)) begin
      jsat = {1'b0, {(AB-1){1'b1}}};
    end else if (jsum < -(AB+5)'(2 ** (AB - 1))) begin
      jsat = {1'b1, {(AB-1){1'b0}}};
    end else begin
      jsat = AB'(jsum);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      qjtg_pkg::ST_TAU: begin
        mul_a = MB'(idx_r);
        mul_b = MB'(inc_r);
      end
      qjtg_pkg::ST_POW2: begin
        mul_a = MB'(tau_cap);
        mul_b = MB'(tau_cap);
      end
      qjtg_pkg::ST_POW3, qjtg_pkg::ST_POW4, qjtg_pkg::ST_POW5: begin
        mul_a = MB'(pw_hi);
        mul_b = MB'(tau_r);
      end
      qjtg_pkg::ST_JMUL: begin
        mul_a = MB'(delta_r[jidx_r]);
        mul_b = MB'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qjtg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == qjtg_pkg::FUNC_START && !moving_r) begin
            state_nxt = qjtg_pkg::ST_DELTA;
          end else if (in_func == qjtg_pkg::FUNC_TICK && moving_r) begin
            state_nxt = qjtg_pkg::ST_TAU;
          end
        end
      end
      qjtg_pkg::ST_DELTA:  state_nxt = qjtg_pkg::ST_DIV_N;
      qjtg_pkg::ST_DIV_N:  if (dcnt_r == '1) state_nxt = qjtg_pkg::ST_CHECK;
      qjtg_pkg::ST_CHECK:  state_nxt = (quo_r == '0) ? qjtg_pkg::ST_DONE
                                                      : qjtg_pkg::ST_DIV_INC;
      qjtg_pkg::ST_DIV_INC: if (dcnt_r == '1) state_nxt = qjtg_pkg::ST_IDLE;
      qjtg_pkg::ST_TAU:    state_nxt = qjtg_pkg::ST_POW2;
      qjtg_pkg::ST_POW2:   state_nxt = qjtg_pkg::ST_POW3;
      qjtg_pkg::ST_POW3:   state_nxt = qjtg_pkg::ST_POW4;
      qjtg_pkg::ST_POW4:   state_nxt = qjtg_pkg::ST_POW5;
      qjtg_pkg::ST_POW5:   state_nxt = qjtg_pkg::ST_BLEND;
      qjtg_pkg::ST_BLEND:  state_nxt = qjtg_pkg::ST_JMUL;
      qjtg_pkg::ST_JMUL:   state_nxt = qjtg_pkg::ST_JSUM;
      qjtg_pkg::ST_JSUM:   state_nxt = (jidx_r == JB'(NJ - 1)) ? qjtg_pkg::ST_FINISH
                                                                : qjtg_pkg::ST_JMUL;
      qjtg_pkg::ST_FINISH: state_nxt = qjtg_pkg::ST_DONE;
      qjtg_pkg::ST_DONE:   if (out_free) state_nxt = qjtg_pkg::ST_IDLE;
      default:             state_nxt = qjtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != qjtg_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= qjtg_pkg::ST_IDLE;
      speed_r  <= qjtg_pkg::SPEED_RESET;
      moving_r <= 1'b0;
      idx_r    <= '0;
      total_r  <= '0;
      inc_r    <= '0;
      ovalid_r <= 1'b0;
      for (int j = 0; j < NJ; j++) begin
        cur_r[j]   <= '0;
        start_r[j] <= '0;
        delta_r[j] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr) speed_r <= pwdata[WB-1:0];
      unique case (state_r)
        qjtg_pkg::ST_IDLE: begin
          if (in_acc) begin
            tgt_r[0] <= in_target_a;
            tgt_r[1] <= in_target_b;
            tgt_r[2] <= in_target_c;
          end
        end
        qjtg_pkg::ST_DELTA: begin
          for (int j = 0; j < NJ; j++) begin
            start_r[j] <= cur_r[j];
            delta_r[j] <= dnew[j];
          end
          num_r     <= num_new;
          den_r     <= {speed_eff, 4'b0000};
          rem_r     <= '0;
          quo_r     <= VB'(num_new);
          divisor_r <= NB'({speed_eff, 4'b0000});
          dcnt_r    <= '0;
        end
        qjtg_pkg::ST_DIV_N, qjtg_pkg::ST_DIV_INC: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (trial >= (NB+1)'(divisor_r)) begin
            rem_r <= trial - (NB+1)'(divisor_r);
            quo_r <= {quo_r[VB-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[VB-2:0], 1'b0};
          end
          if (state_r == qjtg_pkg::ST_DIV_INC && dcnt_r == '1) begin
            inc_r    <= (trial >= (NB+1)'(divisor_r) && quo_r[VB-2:15] == '0)
                        ? {quo_r[14:0], 1'b1}
                        : ((quo_r[VB-2:15] != '0) ? 16'hFFFF : {quo_r[14:0], 1'b0});
            idx_r    <= '0;
            moving_r <= 1'b1;
          end
        end
        qjtg_pkg::ST_CHECK: begin
          if (quo_r == '0) begin
            for (int j = 0; j < NJ; j++) begin
              cur_r[j] <= tgt_r[j];
              res_r[j] <= tgt_r[j];
            end
            res_last_r <= 1'b1;
          end else begin
            total_r <= (quo_r[VB-1:SB] != '0) ? '1 : quo_r[SB-1:0];
          end
          rem_r     <= '0;
          quo_r     <= VB'({den_r, 16'h0000});
          divisor_r <= num_r;
          dcnt_r    <= '0;
        end
        qjtg_pkg::ST_POW2: tau_r <= tau_cap;
        qjtg_pkg::ST_POW4: t3_r  <= pw_hi;
        qjtg_pkg::ST_POW5: t4_r  <= pw_hi;
        qjtg_pkg::ST_BLEND: begin
          if (blend < 0) begin
            s_r <= '0;
          end else if (blend > BB'(65536)) begin
            s_r <= 17'h10000;
          end else begin
            s_r <= blend[16:0];
          end
          jidx_r <= '0;
        end
        qjtg_pkg::ST_JSUM: begin
          res_r[jidx_r] <= jsat;
          jidx_r        <= jidx_r + 1'b1;
        end
        qjtg_pkg::ST_FINISH: begin
          res_last_r <= is_last;
          if (is_last) begin
            for (int j = 0; j < NJ; j++) begin
              cur_r[j] <= AB'(DB'(start_r[j]) + delta_r[j]);
            end
            moving_r <= 1'b0;
            idx_r    <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        qjtg_pkg::ST_DONE: begin
          if (out_free) begin
            for (int j = 0; j < NJ; j++) oa_r[j] <= res_r[j];
            olast_r <= res_last_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// File: src/qjtg_checker.sv
// Port-level checker for the quintic joint trajectory generator and its bind.
// Depends on the top level's ports only.
module qjtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_angle_a,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle_a) && $stable(out_last))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_busy_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared straight from idle");

endmodule

bind quintic_joint_trajectory_generator qjtg_checker u_qjtg_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_angle_a(out_angle_a),
  .out_last(out_last)
);
